@@ rtl/core/bta_pkg.sv @@
// ----------------------------------------------------------------------------
// Boundary-tag allocator package
// Shared constants, request and response codes and the transaction payload
// types of the first-fit boundary-tag allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

   // Default heap size in bytes; the heap is organized as 8-byte words.
   localparam int BTA_HEAP_BYTES = 1024;

   // Request kinds.
   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT     = 2'd1;
   localparam logic [1:0] STATUS_MISALIGNED = 2'd2;

   // Size of the header plus footer pair in bytes.
   localparam int TAG_BYTES = 16;

   // Request transaction payload.
   typedef struct packed {
      logic        req_type;
      logic [10:0] length;
      logic [9:0]  address;
   } bta_req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  payload_offset;
      logic [10:0] block_bytes;
   } bta_rsp_type;

endpackage

@@ rtl/core/bta_tag_mem.sv @@
// ----------------------------------------------------------------------------
// Boundary-tag memory
// One tag word per heap word, one read and one write port, registered read
// data. After reset a sweep writes the initial heap image: one free block
// spanning the whole heap. The sweep writes one heap word per cycle.
// ----------------------------------------------------------------------------
module bta_tag_mem
   import bta_pkg::*;
#(
   parameter int HEAP_BYTES = BTA_HEAP_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(HEAP_BYTES/8)-1:0]    rd_addr,
   output logic [$clog2(HEAP_BYTES):0]        rd_data,
   input  logic                               wr_en,
   input  logic [$clog2(HEAP_BYTES/8)-1:0]    wr_addr,
   input  logic [$clog2(HEAP_BYTES):0]        wr_data,
   output logic                               ready
);

   localparam int WORDS = HEAP_BYTES / 8;
   localparam int AW    = $clog2(WORDS);
   localparam int TW    = $clog2(HEAP_BYTES) + 1;

   logic [TW-1:0] mem [WORDS];
   logic [TW-1:0] rd_data_ff;

   logic          clear_busy_ff;
   logic          clear_busy_in;
   logic [AW-1:0] clear_ptr_ff;
   logic [AW-1:0] clear_ptr_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [TW-1:0] mem_wdata;

   // Clearing sweep: header at the first word, footer at the last word.
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_ptr_in  = clear_ptr_ff;
      if (clear_busy_ff) begin
         clear_ptr_in = clear_ptr_ff + AW'(1);
         if (clear_ptr_ff == AW'(WORDS - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_ptr_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_ptr_ff  <= clear_ptr_in;
      end
   end

   // The sweep owns the write port until it is done.
   always_comb begin
      if (clear_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_ptr_ff;
         if (clear_ptr_ff == '0 || clear_ptr_ff == AW'(WORDS - 1)) begin
            mem_wdata = TW'(HEAP_BYTES);
         end else begin
            mem_wdata = '0;
         end
      end else begin
         mem_we    = wr_en;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end
   end

   // Storage array with a registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clear_busy_ff;

endmodule

@@ rtl/core/boundary_tag_first_fit_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Boundary-tag first-fit allocator
// Manages a heap as an implicit list of blocks with header and footer tags,
// serving allocate and release transactions one at a time.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. An allocate walks the block
// headers from the start of the heap, one header per cycle through the tag
// memory's read port. When a free block fits, it writes the granted block's
// header and footer and, when the block is split, then the header and footer
// of the remainder; when nothing fits, no tag is written and the result is a
// no-fit. Every block holds at least 16 bytes. A release walks the same way
// to find its block, then reads both neighbor tags and writes the merged
// tags. A misaligned release skips the walk. The next request is taken once
// the current result sits in the output register, even if it has not yet
// been taken. After reset the tag memory is initialized by a sweep over
// every heap word, during which req_stall stays high.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_core
   import bta_pkg::*;
#(
   parameter int HEAP_BYTES = BTA_HEAP_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bta_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bta_rsp_type rsp_data
);

   localparam int WORDS  = HEAP_BYTES / 8;
   localparam int AW     = $clog2(WORDS);
   localparam int NW     = AW + 1;
   localparam int TW     = $clog2(HEAP_BYTES) + 1;
   localparam int HB_LOG = $clog2(HEAP_BYTES);
   localparam int CW     = (HB_LOG + 4 > 13) ? HB_LOG + 4 : 13;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_ALLOC_W0,
      ST_ALLOC_W1,
      ST_ALLOC_W2,
      ST_ALLOC_W3,
      ST_REL_PREV,
      ST_REL_NEXT,
      ST_REL_W0,
      ST_REL_W1,
      ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic          kind_ff, kind_in;
   logic [9:0]    addr_ff, addr_in;
   logic [CW-1:0] need_ff, need_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [NW-1:0] n_ff, n_in;
   logic [CW-1:0] blk_ff, blk_in;
   logic [CW-1:0] rest_ff, rest_in;
   logic          split_ff, split_in;
   logic [CW-1:0] size_ff, size_in;
   logic [CW-1:0] start_ff, start_in;
   logic [CW-1:0] total_ff, total_in;
   bta_rsp_type   res_ff, res_in;
   bta_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          mem_ready;
   logic [AW-1:0] rd_addr;
   logic [TW-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [TW-1:0] wr_data;

   logic          req_accept;
   logic          slot_free;
   logic [CW-1:0] tag_size;
   logic          tag_free;
   logic          in_loop;
   logic [CW-1:0] len_round;
   logic [CW-1:0] wr_pos;
   logic [CW-1:0] wr_val;
   logic          wr_req;
   logic [CW-1:0] next_pos;

   // Tag memory with its initialization sweep.
   bta_tag_mem #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_tag_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .ready   (mem_ready)
   );

   assign req_stall  = (state_ff != ST_IDLE) || !mem_ready;
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // Decode of the tag word returned by the memory.
   assign tag_size = CW'({rd_data[TW-1:3], 3'b000});
   assign tag_free = (rd_data[2:0] == 3'b000);
   assign in_loop  = (n_ff < NW'(WORDS)) && (pos_ff < CW'(HEAP_BYTES));
   assign next_pos = pos_ff + tag_size;

   // Payload rounded up to whole words.
   assign len_round = (CW'(req_data.length) + CW'(7)) & ~CW'(7);

   // Write port: a tag write lands only when its word lies inside the heap.
   assign wr_en   = wr_req && (wr_pos < CW'(HEAP_BYTES));
   assign wr_addr = wr_pos[AW+2:3];
   assign wr_data = TW'(wr_val);

   // Next-state and datapath logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      need_in      = need_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      blk_in       = blk_ff;
      rest_in      = rest_ff;
      split_in     = split_ff;
      size_in      = size_ff;
      start_in     = start_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = pos_ff[AW+2:3];
      wr_req       = 1'b0;
      wr_pos       = pos_ff;
      wr_val       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req_accept) begin
               kind_in = req_data.req_type;
               addr_in = req_data.address;
               need_in = len_round + CW'(TAG_BYTES);
               pos_in  = '0;
               n_in    = '0;
               if (req_data.req_type == REQ_RELEASE && req_data.address[2:0] != 3'b000) begin
                  res_in   = '{status: STATUS_MISALIGNED, payload_offset: '0, block_bytes: '0};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         // One block header per cycle.
         ST_WALK: begin
            if (!in_loop) begin
               res_in   = '{status: STATUS_NO_FIT, payload_offset: '0, block_bytes: '0};
               state_in = ST_DONE;
            end else if (kind_ff == REQ_ALLOC) begin
               if (tag_size < CW'(8)) begin
                  res_in   = '{status: STATUS_NO_FIT, payload_offset: '0, block_bytes: '0};
                  state_in = ST_DONE;
               end else if (tag_free && tag_size >= need_ff) begin
                  if (tag_size - need_ff >= CW'(TAG_BYTES)) begin
                     blk_in   = need_ff;
                     rest_in  = tag_size - need_ff;
                     split_in = 1'b1;
                  end else begin
                     blk_in   = tag_size;
                     rest_in  = '0;
                     split_in = 1'b0;
                  end
                  state_in = ST_ALLOC_W0;
               end else begin
                  pos_in  = next_pos;
                  n_in    = n_ff + NW'(1);
                  rd_addr = next_pos[AW+2:3];
               end
            end else begin
               if (pos_ff + CW'(8) == CW'(addr_ff)) begin
                  // Found the block; fetch the footer of the left neighbor.
                  size_in  = tag_size;
                  rd_addr  = AW'((pos_ff - CW'(8)) >> 3);
                  state_in = ST_REL_PREV;
               end else if (tag_size < CW'(8)) begin
                  res_in   = '{status: STATUS_NO_FIT, payload_offset: '0, block_bytes: '0};
                  state_in = ST_DONE;
               end else begin
                  pos_in  = next_pos;
                  n_in    = n_ff + NW'(1);
                  rd_addr = next_pos[AW+2:3];
               end
            end
         end

         // Granted block header and footer, then the split-off remainder.
         ST_ALLOC_W0: begin
            wr_req   = 1'b1;
            wr_pos   = pos_ff;
            wr_val   = blk_ff | CW'(1);
            state_in = ST_ALLOC_W1;
         end

         ST_ALLOC_W1: begin
            wr_req = (blk_ff >= CW'(8));
            wr_pos = pos_ff + blk_ff - CW'(8);
            wr_val = blk_ff | CW'(1);
            res_in = '{status: STATUS_OK,
                       payload_offset: 10'(pos_ff + CW'(8)),
                       block_bytes: 11'(blk_ff)};
            if (split_ff) begin
               state_in = ST_ALLOC_W2;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_ALLOC_W2: begin
            wr_req   = 1'b1;
            wr_pos   = pos_ff + blk_ff;
            wr_val   = rest_ff;
            state_in = ST_ALLOC_W3;
         end

         ST_ALLOC_W3: begin
            wr_req   = (rest_ff >= CW'(8));
            wr_pos   = pos_ff + blk_ff + rest_ff - CW'(8);
            wr_val   = rest_ff;
            state_in = ST_DONE;
         end

         // Merge with a free left neighbor; fetch the right neighbor header.
         ST_REL_PREV: begin
            start_in = pos_ff;
            total_in = size_ff;
            if (pos_ff != '0 && tag_free && tag_size <= pos_ff) begin
               start_in = pos_ff - tag_size;
               total_in = size_ff + tag_size;
            end
            rd_addr  = AW'((pos_ff + size_ff) >> 3);
            state_in = ST_REL_NEXT;
         end

         // Merge with a free right neighbor.
         ST_REL_NEXT: begin
            if (pos_ff + size_ff < CW'(HEAP_BYTES) && tag_free) begin
               total_in = total_ff + tag_size;
            end
            state_in = ST_REL_W0;
         end

         ST_REL_W0: begin
            wr_req   = 1'b1;
            wr_pos   = start_ff;
            wr_val   = total_ff;
            state_in = ST_REL_W1;
         end

         ST_REL_W1: begin
            wr_req   = (total_ff >= CW'(8));
            wr_pos   = start_ff + total_ff - CW'(8);
            wr_val   = total_ff;
            res_in   = '{status: STATUS_OK, payload_offset: '0,
                         block_bytes: 11'(total_ff)};
            state_in = ST_DONE;
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      need_ff  <= need_in;
      pos_ff   <= pos_in;
      n_ff     <= n_in;
      blk_ff   <= blk_in;
      rest_ff  <= rest_in;
      split_ff <= split_in;
      size_ff  <= size_in;
      start_ff <= start_in;
      total_ff <= total_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the boundary-tag first-fit allocator core
// Drives allocate and release transactions into the core and predicts every
// response with a heap image of its own that is kept in step with the core.
// The run starts with a table of directed requests. Random phases follow,
// with and without idling on each side, and a drain of outstanding results
// between phases.
// ----------------------------------------------------------------------------
module tb;
   import bta_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HEAP_BYTES  = BTA_HEAP_BYTES;
   localparam int unsigned HEAP_WORDS  = HEAP_BYTES / 8;
   localparam int unsigned FLAG_MASK   = 7;
   localparam int unsigned TAKEN_FLAG  = 1;
   localparam int          LIMIT_CYCLES = 1_000_000;
   localparam int          SETTLE_CYCLES = 150;
   localparam int          DIRECTED_ROWS = 22;
   localparam int          PHASE_ITEMS = 182;

   // One row of the directed table; when checked_here is set, the response
   // in want is used instead of the predicted one.
   typedef struct packed {
      logic        checked_here;
      bta_req_type req;
      bta_rsp_type want;
   } directed_row_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bta_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bta_rsp_type rsp_data;

   // Heap image of the predictor: one tag per 8-byte word.
   int unsigned heap_tags [HEAP_WORDS];
   // Payload offsets currently granted, used to build sensible releases.
   int unsigned granted_offsets [$];
   // Responses that the core still owes, oldest first.
   bta_rsp_type owed_responses [$];

   directed_row_type directed_rows [DIRECTED_ROWS];

   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int items_sent     = 0;
   int grants_seen    = 0;
   int frees_seen     = 0;
   int no_fit_seen    = 0;
   int misaligned_seen = 0;

   boundary_tag_first_fit_allocator_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
         $display("FAIL boundary_tag_first_fit_allocator_core");
         $finish;
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Heap image access. Reads past the end give an empty tag, writes past
   // the end are dropped.
   // ---------------------------------------------------------------------
   function automatic int unsigned tag_read(int unsigned pos);
      int unsigned w;
      w = pos >> 3;
      return (w < HEAP_WORDS) ? heap_tags[w] : 0;
   endfunction

   function automatic void tag_write(int unsigned pos, int unsigned value);
      int unsigned w;
      w = pos >> 3;
      if (w < HEAP_WORDS) heap_tags[w] = value;
   endfunction

   // Writes the header and, for a real block, the footer.
   function automatic void mark_block(int unsigned pos, int unsigned size,
                                      int unsigned flag);
      tag_write(pos, size | flag);
      if (size >= 8) tag_write(pos + size - 8, size | flag);
   endfunction

   // First-fit allocation with a split only when the remainder can hold
   // its own tags.
   function automatic bta_rsp_type first_fit_allocate(int unsigned len);
      bta_rsp_type res;
      int unsigned need;
      int unsigned pos;
      int unsigned tag;
      int unsigned size;
      res  = '0;
      need = ((len + 7) & ~FLAG_MASK) + TAG_BYTES;
      pos  = 0;
      for (int n = 0; n < HEAP_WORDS && pos < HEAP_BYTES; n++) begin
         tag  = tag_read(pos);
         size = tag & ~FLAG_MASK;
         if (size < 8) break;
         if ((tag & FLAG_MASK) == 0 && size >= need) begin
            if (size - need >= TAG_BYTES) begin
               mark_block(pos, need, TAKEN_FLAG);
               mark_block(pos + need, size - need, 0);
            end else begin
               need = size;
               mark_block(pos, size, TAKEN_FLAG);
            end
            res.status         = STATUS_OK;
            res.payload_offset = 10'(pos + 8);
            res.block_bytes    = 11'(need);
            return res;
         end
         pos += size;
      end
      res.status = STATUS_NO_FIT;
      return res;
   endfunction

   // Release with coalescing of a free neighbor on either side.
   function automatic bta_rsp_type free_and_merge(int unsigned addr);
      bta_rsp_type res;
      int unsigned pos;
      int unsigned size;
      int unsigned start;
      int unsigned total;
      int unsigned tag;
      bit          found;
      res   = '0;
      pos   = 0;
      found = 1'b0;
      if ((addr & FLAG_MASK) != 0) begin
         res.status = STATUS_MISALIGNED;
         return res;
      end
      // Walk the block list looking for the matching payload offset.
      for (int n = 0; n < HEAP_WORDS && pos < HEAP_BYTES; n++) begin
         size = tag_read(pos) & ~FLAG_MASK;
         if (pos + 8 == addr) begin
            found = 1'b1;
            break;
         end
         if (size < 8) break;
         pos += size;
      end
      if (!found) begin
         res.status = STATUS_NO_FIT;
         return res;
      end
      size  = tag_read(pos) & ~FLAG_MASK;
      start = pos;
      total = size;
      if (pos != 0) begin
         tag = tag_read(pos - 8);
         if ((tag & FLAG_MASK) == 0 && (tag & ~FLAG_MASK) <= pos) begin
            start = pos - (tag & ~FLAG_MASK);
            total += tag & ~FLAG_MASK;
         end
      end
      if (pos + size < HEAP_BYTES) begin
         tag = tag_read(pos + size);
         if ((tag & FLAG_MASK) == 0) total += tag & ~FLAG_MASK;
      end
      mark_block(start, total, 0);
      res.status      = STATUS_OK;
      res.block_bytes = 11'(total);
      return res;
   endfunction

   // Payload offset of a randomly chosen block in the list, free or taken.
   function automatic int unsigned any_block_offset();
      int unsigned pos;
      int unsigned size;
      int unsigned starts [$];
      pos = 0;
      for (int n = 0; n < HEAP_WORDS && pos < HEAP_BYTES; n++) begin
         size = tag_read(pos) & ~FLAG_MASK;
         if (size < 8) break;
         starts.push_back(pos + 8);
         pos += size;
      end
      if (starts.size() == 0) return 8;
      return starts[$urandom_range(starts.size() - 1)];
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Idles at random, presents one transaction, holds it
   // until accepted and then updates the heap image and the owed results.
   // ---------------------------------------------------------------------
   task automatic send_request(input bta_req_type r, input logic checked_here,
                               input bta_rsp_type want);
      bta_rsp_type predicted;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      if (r.req_type == REQ_ALLOC) predicted = first_fit_allocate(32'(r.length));
      else predicted = free_and_merge(32'(r.address));
      items_sent++;

      // Keep the list of granted offsets current.
      if (predicted.status == STATUS_OK && r.req_type == REQ_ALLOC) begin
         granted_offsets.push_back(32'(predicted.payload_offset));
         grants_seen++;
      end else if (predicted.status == STATUS_OK) begin
         for (int i = 0; i < granted_offsets.size(); i++) begin
            if (granted_offsets[i] == 32'(r.address)) begin
               granted_offsets.delete(i);
               break;
            end
         end
         frees_seen++;
      end else if (predicted.status == STATUS_NO_FIT) begin
         no_fit_seen++;
      end else begin
         misaligned_seen++;
      end
      owed_responses.push_back(checked_here ? want : predicted);
   endtask

   task automatic wait_for_results();
      while (owed_responses.size() != 0) @(posedge clock);
   endtask

   // Mostly allocations of small blocks and releases of granted blocks, the
   // rest oversized requests, stray and misaligned pointers and releases of
   // blocks that may already be free.
   function automatic bta_req_type random_request();
      bta_req_type r;
      int unsigned roll;
      r.req_type = REQ_ALLOC;
      r.length   = 11'($urandom_range(2047));
      r.address  = 10'($urandom_range(1023));
      roll       = $urandom_range(99);
      if (granted_offsets.size() > 0 &&
          (roll < 40 || (granted_offsets.size() > 12 && roll < 60))) begin
         r.req_type = REQ_RELEASE;
         r.address  = 10'(granted_offsets[$urandom_range(granted_offsets.size() - 1)]);
      end else if (roll < 90) begin
         if ($urandom_range(7) != 0) r.length = 11'($urandom_range(96));
      end else begin
         case ($urandom_range(3))
            0: begin
               r.req_type = REQ_RELEASE;
               r.address  = 10'(($urandom_range(127) << 3) | $urandom_range(1, 7));
            end
            1: begin
               r.req_type = REQ_RELEASE;
               r.address  = 10'($urandom_range(127) << 3);
            end
            2: begin
               r.req_type = REQ_RELEASE;
               r.address  = 10'(any_block_offset());
            end
            default: begin
               r.length = 11'($urandom_range(1009, 2047));
            end
         endcase
      end
      return r;
   endfunction

   task automatic run_random_phase(input int items, input int src_pct,
                                   input int sink_pct);
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      for (int i = 0; i < items; i++) send_request(random_request(), 1'b0, '0);
      req_valid <= 1'b0;
      wait_for_results();
   endtask

   function automatic directed_row_type mk_row(logic checked_here, logic kind,
                                               int unsigned len, int unsigned addr,
                                               logic [1:0] status,
                                               int unsigned offset,
                                               int unsigned bytes);
      directed_row_type row;
      row.checked_here            = checked_here;
      row.req.req_type            = kind;
      row.req.length              = 11'(len);
      row.req.address             = 10'(addr);
      row.want.status             = status;
      row.want.payload_offset     = 10'(offset);
      row.want.block_bytes        = 11'(bytes);
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Response checker: each accepted transaction is compared field by
   // field with the oldest owed result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      bta_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (owed_responses.size() == 0) begin
            $display("%0t: response with none owed: status %0d offset %0d bytes %0d",
                     $time, rsp_data.status, rsp_data.payload_offset,
                     rsp_data.block_bytes);
            error_count++;
         end else begin
            want = owed_responses.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.payload_offset !== want.payload_offset) begin
               $display("%0t: payload_offset expected %0d actual %0d",
                        $time, want.payload_offset, rsp_data.payload_offset);
               error_count++;
            end
            if (rsp_data.block_bytes !== want.block_bytes) begin
               $display("%0t: block_bytes expected %0d actual %0d",
                        $time, want.block_bytes, rsp_data.block_bytes);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      // Heap image after reset: one free block spanning the heap.
      foreach (heap_tags[i]) heap_tags[i] = 0;
      mark_block(0, HEAP_BYTES, 0);

      // Directed requests starting from the empty heap.
      directed_rows = '{
         mk_row(1, REQ_ALLOC,      0, 1023, STATUS_OK,         8,   16),
         mk_row(1, REQ_ALLOC,   1024,    0, STATUS_NO_FIT,     0,    0),
         mk_row(1, REQ_ALLOC,   2047, 1023, STATUS_NO_FIT,     0,    0),
         mk_row(1, REQ_RELEASE, 2047, 1023, STATUS_MISALIGNED, 0,    0),
         mk_row(1, REQ_RELEASE,    0,    4, STATUS_MISALIGNED, 0,    0),
         mk_row(1, REQ_RELEASE,    0,    0, STATUS_NO_FIT,     0,    0),
         mk_row(1, REQ_RELEASE, 1024,   16, STATUS_NO_FIT,     0,    0),
         mk_row(0, REQ_ALLOC,      1,    0, STATUS_OK,         0,    0),
         mk_row(0, REQ_ALLOC,      8,    0, STATUS_OK,         0,    0),
         mk_row(0, REQ_RELEASE,    0,   24, STATUS_OK,         0,    0),
         mk_row(0, REQ_RELEASE,    0,   24, STATUS_OK,         0,    0),
         mk_row(0, REQ_RELEASE,    0,    8, STATUS_OK,         0,    0),
         mk_row(0, REQ_RELEASE,    0,   48, STATUS_OK,         0,    0),
         mk_row(0, REQ_ALLOC,   1000,    0, STATUS_OK,         0,    0),
         mk_row(1, REQ_ALLOC,      0,    0, STATUS_NO_FIT,     0,    0),
         mk_row(1, REQ_RELEASE,    0,    8, STATUS_OK,         0, 1024),
         mk_row(0, REQ_ALLOC,   1008,    0, STATUS_OK,         0,    0),
         mk_row(1, REQ_RELEASE,    0,    8, STATUS_OK,         0, 1024),
         mk_row(0, REQ_ALLOC,    992,    0, STATUS_OK,         0,    0),
         mk_row(0, REQ_ALLOC,      0,    0, STATUS_OK,         0,    0),
         mk_row(0, REQ_RELEASE,    0, 1016, STATUS_OK,         0,    0),
         mk_row(0, REQ_RELEASE,    0,    8, STATUS_OK,         0,    0)
      };

      // Synchronous reset is held and then released; the core then clears its
      // tag memory while it stalls requests.
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].checked_here,
                      directed_rows[i].want);
      end
      req_valid <= 1'b0;
      wait_for_results();

      // Random phases: back to back, idle sender, stalling receiver, both.
      run_random_phase(PHASE_ITEMS,  0,  0);
      run_random_phase(PHASE_ITEMS, 78,  0);
      run_random_phase(PHASE_ITEMS,  0, 78);
      run_random_phase(PHASE_ITEMS, 25, 25);

      sink_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d allocate and release requests: a directed table, then four random phases.",
               items_sent);
      $display("Grants %0d, frees %0d, no-fit %0d, misaligned %0d, mismatches %0d.",
               grants_seen, frees_seen, no_fit_seen, misaligned_seen, error_count);
      if (error_count == 0 && owed_responses.size() == 0) begin
         $display("PASS boundary_tag_first_fit_allocator_core");
      end else begin
         $display("FAIL boundary_tag_first_fit_allocator_core");
      end
      $finish;
   end

endmodule
